// ----- rtl/core/ackp_pkg.sv -----
`timescale 1ns / 1ps

package ackp_pkg;

    localparam int unsigned PN_W    = 48;
    localparam int unsigned DELAY_W = 42;
    localparam int unsigned RANGE_W = 9;
    localparam int unsigned STAMP_W = 8;
    localparam int unsigned BYTES_W = 12;
    localparam int unsigned SKIP_W  = 10;
    localparam int unsigned OUTQ_DEPTH = 4;
    localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int unsigned OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_RANGE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_LARGEST  = 4'd1,
        PH_DELAY    = 4'd2,
        PH_NBLOCKS  = 4'd3,
        PH_FIRSTLEN = 4'd4,
        PH_GAP      = 4'd5,
        PH_BLOCKLEN = 4'd6,
        PH_NTS      = 4'd7,
        PH_SKIP     = 4'd8
    } t_phase;

    typedef struct packed {
        t_kind               kind;
        logic [PN_W-1:0]     range_high;
        logic [PN_W-1:0]     range_low;
        logic [DELAY_W-1:0]  ack_delay_us;
        logic [RANGE_W-1:0]  range_total;
        logic [STAMP_W-1:0]  timestamp_total;
        logic [BYTES_W-1:0]  bytes_used;
        logic                last_of_run;
    } t_item;

    // Up to two result items leave the parser for one frame byte.
    typedef struct packed {
        logic [1:0] count;
        t_item      item0;
        t_item      item1;
    } t_push;

    localparam logic [7:0]  TYPE_MASK     = 8'hC0;
    localparam logic [7:0]  TYPE_ACK      = 8'h40;
    localparam logic [15:0] DELAY_EXP_LSB = 16'd11;
    localparam logic [SKIP_W-1:0] STAMP_FIRST_BYTES = 10'd5;

    // Field length in bytes for a two-bit length code.
    function automatic logic [2:0] len_of(input logic [1:0] code);
        logic [2:0] len;
        case (code)
            2'd0:    len = 3'd1;
            2'd1:    len = 3'd2;
            2'd2:    len = 3'd4;
            default: len = 3'd6;
        endcase
        return len;
    endfunction

    // Unsigned small-float: 5-bit exponent, 11-bit mantissa with hidden bit.
    function automatic logic [DELAY_W-1:0] decode_delay(input logic [15:0] v);
        logic [4:0]         e;
        logic [DELAY_W-1:0] mant;
        logic [DELAY_W-1:0] res;
        e    = v[15:11];
        mant = {{(DELAY_W-12){1'b0}}, 1'b1, v[10:0]};
        if (e == 5'd0) begin
            res = {{(DELAY_W-16){1'b0}}, v};
        end else begin
            res = mant << (e - 5'd1);
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/ack_frame_range_parser.sv -----
`timescale 1ns / 1ps

// Streaming parser for a little-endian ACK frame, one byte per transfer,
// starting with the type byte (frame_start). Each byte is latched in an input
// register, decoded against the parse state, and its results are pushed into a
// four-entry result queue, so a byte is accepted every cycle while the queue
// has room; a result goes through the input register and the queue before it
// is presented. The result side moves one item per cycle while the receiver is
// ready; a byte that yields a range and an early-end error pushes two items,
// and input is held off only while the queue holds more than two. Ranges come
// out as they are found, then one done summary (ack delay, range count,
// timestamp count, bytes consumed) or one error item for a bad type byte or a
// buffer that ends mid-frame. last_of_run marks the final item of each byte.
module ack_frame_range_parser
    import ackp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_start,
    input  logic               i_buffer_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_item_kind,
    output logic [PN_W-1:0]    o_range_high,
    output logic [PN_W-1:0]    o_range_low,
    output logic [DELAY_W-1:0] o_ack_delay_us,
    output logic [RANGE_W-1:0] o_range_total,
    output logic [STAMP_W-1:0] o_timestamp_total,
    output logic [BYTES_W-1:0] o_bytes_used,
    output logic               o_last_of_run
);

    logic       r_in_valid;
    logic [7:0] r_data;
    logic       r_start;
    logic       r_end;
    logic       fire;
    logic       room;
    t_push      push;
    t_item      item;

    assign fire    = r_in_valid && room;
    assign o_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data  <= i_data_byte;
            r_start <= i_frame_start;
            r_end   <= i_buffer_end;
        end
    end

    ackp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_data  (r_data),
        .i_start (r_start),
        .i_end   (r_end),
        .o_push  (push)
    );

    ackp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (item)
    );

    assign o_item_kind       = item.kind;
    assign o_range_high      = item.range_high;
    assign o_range_low       = item.range_low;
    assign o_ack_delay_us    = item.ack_delay_us;
    assign o_range_total     = item.range_total;
    assign o_timestamp_total = item.timestamp_total;
    assign o_bytes_used      = item.bytes_used;
    assign o_last_of_run     = item.last_of_run;

endmodule

// ----- rtl/core/ackp_parse.sv -----
`timescale 1ns / 1ps

module ackp_parse
    import ackp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_data,
    input  logic       i_start,
    input  logic       i_end,
    output t_push      o_push
);

    t_phase              r_phase, n_phase, n_phase_raw;
    logic [2:0]          r_idx, n_idx;
    logic [PN_W-1:0]     r_acc, n_acc;
    logic [1:0]          r_ll, n_ll;
    logic [1:0]          r_mm, n_mm;
    logic                r_has_count, n_has_count;
    logic [7:0]          r_blk_left, n_blk_left;
    logic [PN_W-1:0]     r_base, n_base;   // next range high: prior low - gaps - 1
    logic [RANGE_W-1:0]  r_range_cnt, n_range_cnt;
    logic [DELAY_W-1:0]  r_delay, n_delay;
    logic [STAMP_W-1:0]  r_stamps, n_stamps;
    logic [SKIP_W-1:0]   r_skip, n_skip;
    logic [BYTES_W-1:0]  r_bytes, n_bytes;

    logic [PN_W-1:0]     acc_full;
    logic [2:0]          idx_inc;
    logic [2:0]          field_len;
    logic                field_done;
    logic [PN_W-1:0]     diff;
    logic [7:0]          blocks_dec;
    logic [SKIP_W-1:0]   skip_dec;
    logic [SKIP_W-1:0]   stamp_m1;
    logic                good_type;
    logic                step_phase;
    logic                done_now;
    logic                bad_type;
    logic                err_end;
    logic                emit_range;
    t_item               range_item;
    t_item               done_item;
    t_item               err_item;

    assign acc_full   = r_acc | ({{(PN_W-8){1'b0}}, i_data} << {r_idx, 3'b000});
    assign idx_inc    = r_idx + 3'd1;
    assign field_len  = (r_phase == PH_LARGEST) ? len_of(r_ll) :
                        (r_phase == PH_DELAY)   ? 3'd2 : len_of(r_mm);
    assign field_done = (idx_inc >= field_len);
    assign diff       = r_base - acc_full;
    assign blocks_dec = r_blk_left - 8'd1;
    assign skip_dec   = r_skip - 10'd1;
    assign stamp_m1   = {2'b00, i_data} - 10'd1;
    assign good_type  = ((i_data & TYPE_MASK) == TYPE_ACK);

    assign step_phase = !i_start && (r_phase inside {[PH_LARGEST:PH_SKIP]});
    assign done_now   = step_phase && (n_phase_raw == PH_IDLE);
    assign bad_type   = i_start && !good_type;
    assign err_end    = i_end && ((i_start && good_type) || (step_phase && !done_now));

    assign n_phase    = err_end ? PH_IDLE : n_phase_raw;

    // next state
    always_comb begin
        n_phase_raw = r_phase;
        if (i_start) begin
            n_phase_raw = good_type ? PH_LARGEST : PH_IDLE;
        end else begin
            case (r_phase)
                PH_IDLE:     n_phase_raw = PH_IDLE;
                PH_LARGEST:  n_phase_raw = field_done ? PH_DELAY : PH_LARGEST;
                PH_DELAY: begin
                    if (field_done) begin
                        n_phase_raw = r_has_count ? PH_NBLOCKS : PH_FIRSTLEN;
                    end
                end
                PH_NBLOCKS:  n_phase_raw = PH_FIRSTLEN;
                PH_FIRSTLEN: begin
                    if (field_done) begin
                        n_phase_raw = (r_blk_left != 8'd0) ? PH_GAP : PH_NTS;
                    end
                end
                PH_GAP:      n_phase_raw = PH_BLOCKLEN;
                PH_BLOCKLEN: begin
                    if (field_done) begin
                        n_phase_raw = (blocks_dec != 8'd0) ? PH_GAP : PH_NTS;
                    end
                end
                PH_NTS:      n_phase_raw = (i_data != 8'd0) ? PH_SKIP : PH_IDLE;
                PH_SKIP:     n_phase_raw = (skip_dec == '0) ? PH_IDLE : PH_SKIP;
                default:     n_phase_raw = PH_IDLE;
            endcase
        end
    end

    // datapath and result items
    always_comb begin
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_ll        = r_ll;
        n_mm        = r_mm;
        n_has_count = r_has_count;
        n_blk_left  = r_blk_left;
        n_base      = r_base;
        n_range_cnt = r_range_cnt;
        n_delay     = r_delay;
        n_stamps    = r_stamps;
        n_skip      = r_skip;
        n_bytes     = r_bytes;
        emit_range  = 1'b0;

        if (i_start) begin
            n_idx       = '0;
            n_acc       = '0;
            n_ll        = i_data[3:2];
            n_mm        = i_data[1:0];
            n_has_count = i_data[5];
            n_blk_left  = '0;
            n_base      = '0;
            n_range_cnt = '0;
            n_delay     = '0;
            n_stamps    = '0;
            n_skip      = '0;
            n_bytes     = {{(BYTES_W-1){1'b0}}, 1'b1};
        end else if (step_phase) begin
            n_bytes = r_bytes + 12'd1;
            case (r_phase)
                PH_LARGEST, PH_DELAY, PH_FIRSTLEN, PH_BLOCKLEN: begin
                    n_idx = idx_inc;
                    n_acc = acc_full;
                    if (field_done) begin
                        n_idx = '0;
                        n_acc = '0;
                        if (r_phase == PH_LARGEST) begin
                            n_base = acc_full;
                        end else if (r_phase == PH_DELAY) begin
                            n_delay    = decode_delay(acc_full[15:0]);
                            n_blk_left = '0;
                        end else if (r_phase == PH_FIRSTLEN) begin
                            emit_range  = 1'b1;
                            n_base      = diff;
                            n_range_cnt = {{(RANGE_W-1){1'b0}}, 1'b1};
                        end else begin
                            n_blk_left = blocks_dec;
                            if (acc_full != '0) begin
                                emit_range  = 1'b1;
                                n_base      = diff;
                                n_range_cnt = r_range_cnt + 9'd1;
                            end
                        end
                    end
                end
                PH_NBLOCKS: n_blk_left = i_data;
                PH_GAP:     n_base = r_base - {{(PN_W-8){1'b0}}, i_data};
                PH_NTS: begin
                    n_stamps = i_data;
                    n_skip   = STAMP_FIRST_BYTES + stamp_m1 + {stamp_m1[SKIP_W-2:0], 1'b0};
                end
                PH_SKIP:    n_skip = skip_dec;
                default:    n_skip = r_skip;
            endcase
        end
    end

    always_comb begin
        range_item            = '0;
        range_item.kind       = KIND_RANGE;
        range_item.range_high = r_base;
        range_item.range_low  = diff + 48'd1;
        range_item.last_of_run = !err_end;

        done_item                 = '0;
        done_item.kind            = KIND_DONE;
        done_item.ack_delay_us    = n_delay;
        done_item.range_total     = n_range_cnt;
        done_item.timestamp_total = n_stamps;
        done_item.bytes_used      = n_bytes;
        done_item.last_of_run     = 1'b1;

        err_item             = '0;
        err_item.kind        = KIND_ERROR;
        err_item.last_of_run = 1'b1;

        o_push = '0;
        if (bad_type) begin
            o_push.count = 2'd1;
            o_push.item0 = err_item;
        end else if (done_now) begin
            o_push.count = 2'd1;
            o_push.item0 = done_item;
        end else if (emit_range) begin
            o_push.item0 = range_item;
            o_push.item1 = err_item;
            o_push.count = err_end ? 2'd2 : 2'd1;
        end else if (err_end) begin
            o_push.count = 2'd1;
            o_push.item0 = err_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_acc       <= n_acc;
            r_ll        <= n_ll;
            r_mm        <= n_mm;
            r_has_count <= n_has_count;
            r_blk_left  <= n_blk_left;
            r_base      <= n_base;
            r_range_cnt <= n_range_cnt;
            r_delay     <= n_delay;
            r_stamps    <= n_stamps;
            r_skip      <= n_skip;
            r_bytes     <= n_bytes;
        end
    end

endmodule

// ----- rtl/core/ackp_outq.sv -----
`timescale 1ns / 1ps

module ackp_outq
    import ackp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_fire,
    input  t_push i_push,
    output logic  o_room,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    t_item                 r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [OUTQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [OUTQ_CNT_W-1:0] r_count, n_count;
    logic [1:0]            push_cnt;
    logic                  pop;
    logic [OUTQ_PTR_W-1:0] wr_ptr1;

    assign push_cnt = i_fire ? i_push.count : 2'd0;
    assign pop      = o_valid && i_ready;
    assign wr_ptr1  = r_wr_ptr + OUTQ_PTR_W'(1);
    assign o_valid  = (r_count != '0);
    // room for a two-item burst
    assign o_room   = (r_count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
    assign o_item   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + OUTQ_PTR_W'(push_cnt);
        n_rd_ptr = r_rd_ptr + OUTQ_PTR_W'(pop);
        n_count  = r_count + OUTQ_CNT_W'(push_cnt) - OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.item0;
        end
        if (push_cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.item1;
        end
    end

endmodule

// ----- rtl/core/ackp_checker.sv -----
`timescale 1ns / 1ps

module ackp_checker
    import ackp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [1:0]         o_item_kind,
    input logic [PN_W-1:0]    o_range_high,
    input logic [PN_W-1:0]    o_range_low,
    input logic [DELAY_W-1:0] o_ack_delay_us,
    input logic [RANGE_W-1:0] o_range_total,
    input logic [STAMP_W-1:0] o_timestamp_total,
    input logic [BYTES_W-1:0] o_bytes_used,
    input logic               o_last_of_run
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item_kind)
            && $stable(o_range_high) && $stable(o_range_low)
            && $stable(o_bytes_used) && $stable(o_last_of_run))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> o_ready && !o_valid)
        else $error("not empty after reset");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item_kind == KIND_ERROR |-> o_last_of_run
            && o_range_high == '0 && o_range_low == '0 && o_ack_delay_us == '0
            && o_range_total == '0 && o_timestamp_total == '0 && o_bytes_used == '0)
        else $error("error item carries data");

    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item_kind == KIND_DONE |-> o_last_of_run
            && o_range_total != '0 && o_bytes_used != '0
            && o_range_high == '0 && o_range_low == '0)
        else $error("malformed done item");

    // only a range followed by an early-end error shares a byte
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_run |=> o_valid && o_item_kind == KIND_ERROR)
        else $error("second item of a byte missing");

endmodule

bind ack_frame_range_parser ackp_checker u_ackp_checker (.*);
